// File: sv/f8a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f8a_pkg: shared types and constants of the Fletcher-8 frame appender
// Frame geometry, index width and the record passed from the sum core to
// the output sequencer.
// ----------------------------------------------------------------------------
package f8a_pkg;

   localparam int HEADER_BYTES = 6;
   localparam int BYTE_W       = 8;
   localparam int IDX_W        = 9;

   // Position of the length byte inside the header
   localparam logic [IDX_W-1:0] LEN_POS = IDX_W'(HEADER_BYTES - 1);
   localparam logic [IDX_W-1:0] HDR_LEN = IDX_W'(HEADER_BYTES);

   // One processed request as seen by the output sequencer
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [BYTE_W-1:0] sum_a;
      logic [BYTE_W-1:0] sum_b;
   } sum_res_type;

   // Output sequencer: which checksum bytes are still owed
   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_SUM_A,
      TAIL_SUM_B
   } tail_type;

endpackage
`default_nettype wire

// File: sv/f8a_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f8a_in_stage: input request register
// Holds one request byte until the sum core takes it.
// ----------------------------------------------------------------------------
module f8a_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [f8a_pkg::BYTE_W-1:0] req_data_byte,
   output logic                           hold_valid,
   output logic [f8a_pkg::BYTE_W-1:0]     hold_data,
   input  wire logic                      take
);
   import f8a_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              req_fire;

   assign req_ready  = !valid_ff || take;
   assign req_fire   = req_valid && req_ready;
   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         data_in  = req_data_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// File: sv/f8a_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f8a_sum: Fletcher-8 sum core
// Updates both running sums, the frame position and the captured length for
// each byte taken, and flags the last byte of a frame.
// ----------------------------------------------------------------------------
module f8a_sum (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      take,
   input  wire logic [f8a_pkg::BYTE_W-1:0] data,
   output f8a_pkg::sum_res_type           res
);
   import f8a_pkg::*;

   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] new_a, new_b, cur_len;
   logic [IDX_W-1:0]  idx_next;
   logic              last;

   always_comb begin
      new_a    = sum_a_ff + data;
      new_b    = sum_b_ff + new_a;
      cur_len  = (idx_ff == LEN_POS) ? data : len_ff;
      idx_next = idx_ff + IDX_W'(1);
      last     = (idx_ff >= LEN_POS) && (idx_next == (HDR_LEN + IDX_W'(cur_len)));

      res.data  = data;
      res.last  = last;
      res.sum_a = new_a;
      res.sum_b = new_b;

      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      if (take) begin
         if (last) begin
            // frame done: clear for the next one
            sum_a_in = '0;
            sum_b_in = '0;
            idx_in   = '0;
            len_in   = '0;
         end else begin
            sum_a_in = new_a;
            sum_b_in = new_b;
            idx_in   = idx_next;
            len_in   = cur_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         idx_ff   <= '0;
         len_ff   <= '0;
      end else begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
      end
   end

   // the position never runs past the end of a maximum-length frame
   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= HDR_LEN + IDX_W'(255))
      else $error("f8a_sum: frame position out of range");

endmodule
`default_nettype wire

// File: sv/f8a_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f8a_out: response sequencer
// Registers the passed-through byte and, at frame end, follows it with
// sum A and sum B on the next two response transfers.
// ----------------------------------------------------------------------------
module f8a_out (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      src_valid,
   input  wire f8a_pkg::sum_res_type      src,
   output logic                           take,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [f8a_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_is_checksum,
   output logic                           rsp_frame_end
);
   import f8a_pkg::*;

   tail_type          tail_ff, tail_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              chk_ff, chk_in;
   logic              end_ff, end_in;
   logic [BYTE_W-1:0] hold_a_ff, hold_a_in;
   logic [BYTE_W-1:0] hold_b_ff, hold_b_in;
   logic              rsp_fire;
   logic              free;

   assign rsp_fire        = valid_ff && rsp_ready;
   assign free            = (tail_ff == TAIL_NONE) && (!valid_ff || rsp_ready);
   assign take            = free && src_valid;
   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_is_checksum = chk_ff;
   assign rsp_frame_end   = end_ff;

   always_comb begin
      tail_in   = tail_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      chk_in    = chk_ff;
      end_in    = end_ff;
      hold_a_in = hold_a_ff;
      hold_b_in = hold_b_ff;
      case (tail_ff)
         TAIL_NONE: begin
            if (take) begin
               valid_in  = 1'b1;
               byte_in   = src.data;
               chk_in    = 1'b0;
               end_in    = 1'b0;
               hold_a_in = src.sum_a;
               hold_b_in = src.sum_b;
               tail_in   = src.last ? TAIL_SUM_A : TAIL_NONE;
            end else if (rsp_fire) begin
               valid_in = 1'b0;
            end
         end
         TAIL_SUM_A: begin
            if (rsp_fire) begin
               byte_in = hold_a_ff;
               chk_in  = 1'b1;
               end_in  = 1'b0;
               tail_in = TAIL_SUM_B;
            end
         end
         TAIL_SUM_B: begin
            if (rsp_fire) begin
               byte_in = hold_b_ff;
               chk_in  = 1'b1;
               end_in  = 1'b1;
               tail_in = TAIL_NONE;
            end
         end
         default: begin
            tail_in = TAIL_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff  <= TAIL_NONE;
         valid_ff <= 1'b0;
      end else begin
         tail_ff  <= tail_in;
         valid_ff <= valid_in;
      end
      byte_ff   <= byte_in;
      chk_ff    <= chk_in;
      end_ff    <= end_in;
      hold_a_ff <= hold_a_in;
      hold_b_ff <= hold_b_in;
   end

   // sum B always follows sum A on the very next transfer slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && chk_ff && !end_ff) |=> (valid_ff && chk_ff && end_ff))
      else $error("f8a_out: sum B did not follow sum A");

   // while checksum bytes are owed, the output register is occupied
   assert property (@(posedge clock) disable iff (reset)
      (tail_ff != TAIL_NONE) |-> valid_ff)
      else $error("f8a_out: checksum pending with empty output");

   // no new request enters while a frame's checksum is pending
   assert property (@(posedge clock) disable iff (reset)
      take |-> (tail_ff == TAIL_NONE))
      else $error("f8a_out: request taken during checksum tail");

   // frame end marks only a checksum byte (sum B)
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && end_ff) |-> chk_ff)
      else $error("f8a_out: frame end on a data byte");

endmodule
`default_nettype wire

// File: sv/frame_fletcher8_appender.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_fletcher8_appender: pass-through with Fletcher-8 trailer
// Passes message bytes (header, then payload) through unchanged and, after
// the last payload byte, appends sum A and then sum B. The last header byte
// carries the payload length.
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   request | req_valid, req_ready, req_data_byte       | in
//   response| rsp_valid, rsp_ready, rsp_out_byte,       | out
//           | rsp_is_checksum, rsp_frame_end            |
//
// Flow: one request per clock while the response side is ready and no
//   trailer is pending. After the last byte of a frame the single output
//   register sends sum A and then sum B before it takes another byte.
// Reset: synchronous, clears the sums, frame position and captured length.
// Stalls: a held response blocks the sum core; the input register still
//   takes one more request, then req_ready drops until the output drains.
// ----------------------------------------------------------------------------
module frame_fletcher8_appender (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [f8a_pkg::BYTE_W-1:0] req_data_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [f8a_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_is_checksum,
   output logic                           rsp_frame_end
);
   import f8a_pkg::*;

   logic              hold_valid;
   logic [BYTE_W-1:0] hold_data;
   logic              take;
   sum_res_type       res;

   // hold the incoming request byte
   f8a_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .hold_valid    (hold_valid),
      .hold_data     (hold_data),
      .take          (take)
   );

   // advance the sums and frame position on every byte taken
   f8a_sum u_sum (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .data  (hold_data),
      .res   (res)
   );

   // register the byte, then drop in the trailer at frame end
   f8a_out u_out (
      .clock           (clock),
      .reset           (reset),
      .src_valid       (hold_valid),
      .src             (res),
      .take            (take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_checksum (rsp_is_checksum),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule
`default_nettype wire
